// ===== rtl/core/c65alu_pkg.sv =====
// ----------------------------------------------------------------------------
// c65alu_pkg
// Shared types and constants for the 6502 execute unit: operation codes,
// status bit positions, register file and result structures.
// ----------------------------------------------------------------------------
`default_nettype none

package c65alu_pkg;

    typedef enum logic [5:0] {
        OP_NOP    = 6'd0,
        OP_LDA    = 6'd1,
        OP_LDX    = 6'd2,
        OP_LDY    = 6'd3,
        OP_STA    = 6'd4,
        OP_STX    = 6'd5,
        OP_STY    = 6'd6,
        OP_TAX    = 6'd7,
        OP_TAY    = 6'd8,
        OP_TXA    = 6'd9,
        OP_TYA    = 6'd10,
        OP_TSX    = 6'd11,
        OP_TXS    = 6'd12,
        OP_INX    = 6'd13,
        OP_INY    = 6'd14,
        OP_DEX    = 6'd15,
        OP_DEY    = 6'd16,
        OP_INC    = 6'd17,
        OP_DEC    = 6'd18,
        OP_ADC    = 6'd19,
        OP_SBC    = 6'd20,
        OP_AND    = 6'd21,
        OP_ORA    = 6'd22,
        OP_EOR    = 6'd23,
        OP_CMP    = 6'd24,
        OP_CPX    = 6'd25,
        OP_CPY    = 6'd26,
        OP_BIT    = 6'd27,
        OP_ASL_A  = 6'd28,
        OP_LSR_A  = 6'd29,
        OP_ROL_A  = 6'd30,
        OP_ROR_A  = 6'd31,
        OP_ASL_M  = 6'd32,
        OP_LSR_M  = 6'd33,
        OP_ROL_M  = 6'd34,
        OP_ROR_M  = 6'd35,
        OP_CLC    = 6'd36,
        OP_SEC    = 6'd37,
        OP_CLI    = 6'd38,
        OP_SEI    = 6'd39,
        OP_CLD    = 6'd40,
        OP_SED    = 6'd41,
        OP_CLV    = 6'd42,
        OP_PHA    = 6'd43,
        OP_PHP    = 6'd44,
        OP_PLA    = 6'd45,
        OP_PLP    = 6'd46,
        OP_BPL    = 6'd47,
        OP_BMI    = 6'd48,
        OP_BVC    = 6'd49,
        OP_BVS    = 6'd50,
        OP_BCC    = 6'd51,
        OP_BCS    = 6'd52,
        OP_BNE    = 6'd53,
        OP_BEQ    = 6'd54
    } t_op;

    // status bit positions
    localparam int unsigned FLAG_C = 0;
    localparam int unsigned FLAG_Z = 1;
    localparam int unsigned FLAG_I = 2;
    localparam int unsigned FLAG_D = 3;
    localparam int unsigned FLAG_B = 4;
    localparam int unsigned FLAG_U = 5;
    localparam int unsigned FLAG_V = 6;
    localparam int unsigned FLAG_N = 7;

    localparam logic [7:0] RST_P = 8'h24;
    localparam logic [7:0] RST_S = 8'hFD;

    typedef struct packed {
        logic [7:0] a;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] p;
        logic [7:0] s;
    } t_regs;

    typedef struct packed {
        logic [7:0] store_data;
        logic       store_valid;
        logic       branch_taken;
    } t_result;

endpackage

`default_nettype wire

// ===== rtl/core/c65alu_if.sv =====
// ----------------------------------------------------------------------------
// c65alu_if
// Valid/ready channels of the 6502 execute unit: operation in, register
// snapshot and store/branch result out.
// ----------------------------------------------------------------------------
`default_nettype none

interface c65alu_in_if;
    logic       valid;
    logic       ready;
    logic [5:0] op;
    logic [7:0] operand;

    modport source (output valid, output op, output operand, input ready);
    modport sink   (input valid, input op, input operand, output ready);
endinterface

interface c65alu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] acc_out;
    logic [7:0] x_out;
    logic [7:0] y_out;
    logic [7:0] status_out;
    logic [7:0] store_data;
    logic       store_valid;
    logic       branch_taken;

    modport source (
        output valid, output acc_out, output x_out, output y_out,
        output status_out, output store_data, output store_valid,
        output branch_taken, input ready
    );
    modport sink (
        input valid, input acc_out, input x_out, input y_out,
        input status_out, input store_data, input store_valid,
        input branch_taken, output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/c65alu_exec.sv =====
// ----------------------------------------------------------------------------
// c65alu_exec
// Combinational execute step: decodes one operation, computes the binary
// and BCD adder, shifter, compare and flag updates, and returns the next
// register file together with the store and branch result.
// ----------------------------------------------------------------------------
`default_nettype none

module c65alu_exec (
    input  wire logic [5:0]         i_op,
    input  wire logic [7:0]         i_operand,
    input  c65alu_pkg::t_regs       i_regs,
    output c65alu_pkg::t_regs       o_regs,
    output c65alu_pkg::t_result     o_res
);
    import c65alu_pkg::*;

    t_op        w_op;
    logic [7:0] a, m;
    logic       cin;

    logic [8:0] adc_bin, sbc_bin;
    logic       adc_v, sbc_v;
    logic [4:0] dlo, dlo_fix;
    logic [9:0] dt, dt_fix;
    logic [9:0] sl, sl_fix, st, st_fix;

    logic [7:0] sh_src, sh_res;
    logic       sh_c;

    logic [7:0] cmp_src;
    logic [8:0] cmp_diff;

    logic       nz_en;
    logic [7:0] nz_val;
    t_regs      n;
    t_result    res;

    assign w_op = t_op'(i_op);
    assign a    = i_regs.a;
    assign m    = i_operand;
    assign cin  = i_regs.p[FLAG_C];

    // binary adder paths
    assign adc_bin = {1'b0, a} + {1'b0, m} + {8'b0, cin};
    assign sbc_bin = {1'b0, a} + {1'b0, ~m} + {8'b0, cin};
    assign adc_v   = ~(a[7] ^ m[7]) & (a[7] ^ adc_bin[7]);
    assign sbc_v   = (a[7] ^ m[7]) & (a[7] ^ sbc_bin[7]);

    // decimal add
    assign dlo     = {1'b0, a[3:0]} + {1'b0, m[3:0]} + {4'b0, cin};
    assign dlo_fix = (dlo >= 5'd10) ? {1'b1, dlo[3:0] + 4'd6} : dlo;
    assign dt      = {2'b0, a[7:4], 4'b0} + {2'b0, m[7:4], 4'b0} + {5'b0, dlo_fix};
    assign dt_fix  = (dt >= 10'h0A0) ? dt + 10'h060 : dt;

    // decimal subtract, two's complement over ten bits
    assign sl     = {6'b0, a[3:0]} - {6'b0, m[3:0]} + {9'b0, cin} - 10'd1;
    assign sl_fix = sl[9] ? ({6'b0, sl[3:0] - 4'd6} - 10'h010) : sl;
    assign st     = {2'b0, a[7:4], 4'b0} - {2'b0, m[7:4], 4'b0} + sl_fix;
    assign st_fix = st[9] ? st - 10'h060 : st;

    // shifter, kind in the low two op bits for both A and memory forms
    assign sh_src = i_op[5] ? m : a;
    always_comb begin
        case (i_op[1:0])
            2'd0: begin
                sh_c   = sh_src[7];
                sh_res = {sh_src[6:0], 1'b0};
            end
            2'd1: begin
                sh_c   = sh_src[0];
                sh_res = {1'b0, sh_src[7:1]};
            end
            2'd2: begin
                sh_c   = sh_src[7];
                sh_res = {sh_src[6:0], cin};
            end
            default: begin
                sh_c   = sh_src[0];
                sh_res = {cin, sh_src[7:1]};
            end
        endcase
    end

    always_comb begin
        case (w_op)
            OP_CPX:  cmp_src = i_regs.x;
            OP_CPY:  cmp_src = i_regs.y;
            default: cmp_src = a;
        endcase
    end
    assign cmp_diff = {1'b0, cmp_src} - {1'b0, m};

    always_comb begin
        n      = i_regs;
        res    = '0;
        nz_en  = 1'b0;
        nz_val = 8'h00;
        unique case (w_op) inside
            OP_LDA: begin n.a = m; nz_en = 1'b1; nz_val = m; end
            OP_LDX: begin n.x = m; nz_en = 1'b1; nz_val = m; end
            OP_LDY: begin n.y = m; nz_en = 1'b1; nz_val = m; end
            OP_STA: begin res.store_data = a;        res.store_valid = 1'b1; end
            OP_STX: begin res.store_data = i_regs.x; res.store_valid = 1'b1; end
            OP_STY: begin res.store_data = i_regs.y; res.store_valid = 1'b1; end
            OP_TAX: begin n.x = a; nz_en = 1'b1; nz_val = a; end
            OP_TAY: begin n.y = a; nz_en = 1'b1; nz_val = a; end
            OP_TXA: begin n.a = i_regs.x; nz_en = 1'b1; nz_val = i_regs.x; end
            OP_TYA: begin n.a = i_regs.y; nz_en = 1'b1; nz_val = i_regs.y; end
            OP_TSX: begin n.x = i_regs.s; nz_en = 1'b1; nz_val = i_regs.s; end
            OP_TXS: n.s = i_regs.x;
            OP_INX: begin
                n.x = i_regs.x + 8'd1; nz_en = 1'b1; nz_val = n.x;
            end
            OP_INY: begin
                n.y = i_regs.y + 8'd1; nz_en = 1'b1; nz_val = n.y;
            end
            OP_DEX: begin
                n.x = i_regs.x - 8'd1; nz_en = 1'b1; nz_val = n.x;
            end
            OP_DEY: begin
                n.y = i_regs.y - 8'd1; nz_en = 1'b1; nz_val = n.y;
            end
            OP_INC: begin
                res.store_data  = m + 8'd1;
                res.store_valid = 1'b1;
                nz_en = 1'b1; nz_val = res.store_data;
            end
            OP_DEC: begin
                res.store_data  = m - 8'd1;
                res.store_valid = 1'b1;
                nz_en = 1'b1; nz_val = res.store_data;
            end
            OP_ADC: begin
                if (!i_regs.p[FLAG_D]) begin
                    n.a         = adc_bin[7:0];
                    n.p[FLAG_C] = adc_bin[8];
                    n.p[FLAG_V] = adc_v;
                    nz_en = 1'b1; nz_val = adc_bin[7:0];
                end else begin
                    // Z from the binary sum, N and V after the low fix-up
                    n.a         = dt_fix[7:0];
                    n.p[FLAG_C] = (dt_fix >= 10'h100);
                    n.p[FLAG_Z] = (adc_bin[7:0] == 8'h00);
                    n.p[FLAG_N] = dt[7];
                    n.p[FLAG_V] = ~(a[7] ^ m[7]) & (a[7] ^ dt[7]);
                end
            end
            OP_SBC: begin
                n.a         = i_regs.p[FLAG_D] ? st_fix[7:0] : sbc_bin[7:0];
                n.p[FLAG_C] = sbc_bin[8];
                n.p[FLAG_V] = sbc_v;
                nz_en = 1'b1; nz_val = sbc_bin[7:0];
            end
            OP_AND: begin n.a = a & m; nz_en = 1'b1; nz_val = n.a; end
            OP_ORA: begin n.a = a | m; nz_en = 1'b1; nz_val = n.a; end
            OP_EOR: begin n.a = a ^ m; nz_en = 1'b1; nz_val = n.a; end
            OP_CMP, OP_CPX, OP_CPY: begin
                n.p[FLAG_C] = ~cmp_diff[8];
                nz_en = 1'b1; nz_val = cmp_diff[7:0];
            end
            OP_BIT: begin
                n.p[FLAG_Z] = ((a & m) == 8'h00);
                n.p[FLAG_N] = m[7];
                n.p[FLAG_V] = m[6];
            end
            OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: begin
                n.a         = sh_res;
                n.p[FLAG_C] = sh_c;
                nz_en = 1'b1; nz_val = sh_res;
            end
            OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
                res.store_data  = sh_res;
                res.store_valid = 1'b1;
                n.p[FLAG_C]     = sh_c;
                nz_en = 1'b1; nz_val = sh_res;
            end
            OP_CLC: n.p[FLAG_C] = 1'b0;
            OP_SEC: n.p[FLAG_C] = 1'b1;
            OP_CLI: n.p[FLAG_I] = 1'b0;
            OP_SEI: n.p[FLAG_I] = 1'b1;
            OP_CLD: n.p[FLAG_D] = 1'b0;
            OP_SED: n.p[FLAG_D] = 1'b1;
            OP_CLV: n.p[FLAG_V] = 1'b0;
            OP_PHA: begin
                res.store_data  = a;
                res.store_valid = 1'b1;
                n.s = i_regs.s - 8'd1;
            end
            OP_PHP: begin
                res.store_data         = i_regs.p;
                res.store_data[FLAG_B] = 1'b1;
                res.store_data[FLAG_U] = 1'b1;
                res.store_valid        = 1'b1;
                n.s = i_regs.s - 8'd1;
            end
            OP_PLA: begin
                n.s = i_regs.s + 8'd1;
                n.a = m;
                nz_en = 1'b1; nz_val = m;
            end
            OP_PLP: begin
                n.s         = i_regs.s + 8'd1;
                n.p         = m;
                n.p[FLAG_B] = 1'b0;
                n.p[FLAG_U] = 1'b1;
            end
            OP_BPL: res.branch_taken = ~i_regs.p[FLAG_N];
            OP_BMI: res.branch_taken =  i_regs.p[FLAG_N];
            OP_BVC: res.branch_taken = ~i_regs.p[FLAG_V];
            OP_BVS: res.branch_taken =  i_regs.p[FLAG_V];
            OP_BCC: res.branch_taken = ~i_regs.p[FLAG_C];
            OP_BCS: res.branch_taken =  i_regs.p[FLAG_C];
            OP_BNE: res.branch_taken = ~i_regs.p[FLAG_Z];
            OP_BEQ: res.branch_taken =  i_regs.p[FLAG_Z];
            default: ;
        endcase
        if (nz_en) begin
            n.p[FLAG_Z] = (nz_val == 8'h00);
            n.p[FLAG_N] = nz_val[7];
        end
    end

    assign o_regs = n;
    assign o_res  = res;

endmodule

`default_nettype wire

// ===== rtl/core/cpu6502_alu_register_unit.sv =====
// ----------------------------------------------------------------------------
// cpu6502_alu_register_unit
// Execute unit of a 6502: A, X, Y, P and stack low byte with ALU, BCD
// adder, shifter, flag logic and branch test.
// ----------------------------------------------------------------------------
// Use:
//   i_in carries one operation code and the memory or pulled byte it needs.
//   o_out returns, for every operation, A, X, Y and P after it, the byte to
//   write or push with its strobe, and the branch condition result.
//   Each input transfer gives exactly one output transfer, in order.
// Timing:
//   Operations pass through the input register, then through the execute
//   logic into the result register. One operation per cycle is sustained
//   while the receiver takes each result; the register file is updated as
//   each operation leaves the input register, so the next one sees it at once.
// Reset:
//   Both stages empty; A = X = Y = 0, P = 0x24, S low = 0xFD.
// Stall:
//   While the receiver holds off, the result register holds its transfer,
//   the input register keeps one more operation, and i_in.ready drops.
// ----------------------------------------------------------------------------
`default_nettype none

module cpu6502_alu_register_unit (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    c65alu_in_if.sink      i_in,
    c65alu_out_if.source   o_out
);
    import c65alu_pkg::*;

    logic       r_s1_valid;
    logic [5:0] r_s1_op;
    logic [7:0] r_s1_operand;

    t_regs      r_regs, n_regs;
    t_result    n_res, r_res;
    logic       r_out_valid;

    logic       w_in_xfer;
    logic       w_s1_adv;

    assign w_s1_adv  = r_s1_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_s1_valid || w_s1_adv;
    assign w_in_xfer = i_in.valid && i_in.ready;

    c65alu_exec u_exec (
        .i_op      (r_s1_op),
        .i_operand (r_s1_operand),
        .i_regs    (r_regs),
        .o_regs    (n_regs),
        .o_res     (n_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_in_xfer) begin
            r_s1_valid <= 1'b1;
        end else if (w_s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_xfer) begin
            r_s1_op      <= i_in.op;
            r_s1_operand <= i_in.operand;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs.a <= 8'h00;
            r_regs.x <= 8'h00;
            r_regs.y <= 8'h00;
            r_regs.p <= RST_P;
            r_regs.s <= RST_S;
        end else if (w_s1_adv) begin
            r_regs <= n_regs;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_s1_adv) begin
            r_out_valid <= 1'b1;
        end else if (o_out.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_s1_adv) begin
            r_res <= n_res;
        end
    end

    // result register shows the register file written with it
    assign o_out.valid        = r_out_valid;
    assign o_out.acc_out      = r_regs.a;
    assign o_out.x_out        = r_regs.x;
    assign o_out.y_out        = r_regs.y;
    assign o_out.status_out   = r_regs.p;
    assign o_out.store_data   = r_res.store_data;
    assign o_out.store_valid  = r_res.store_valid;
    assign o_out.branch_taken = r_res.branch_taken;

`ifndef ASSERT_OFF
    a_store_data_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_res.store_valid) |-> (r_res.store_data == 8'h00))
        else $error("store data not zero without store strobe");

    a_store_branch_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> !(r_res.store_valid && r_res.branch_taken))
        else $error("store and branch flagged on one transfer");

    a_status_fixed_bits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_regs.p[FLAG_U] && !r_regs.p[FLAG_B]))
        else $error("status U/B bits corrupted");

    a_regs_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_s1_adv |=> $stable(r_regs))
        else $error("register file changed without an operation");
`endif

endmodule

`default_nettype wire

// ===== sim/cpu6502_alu_register_unit_test.sv =====
// ----------------------------------------------------------------------------
// cpu6502_alu_register_unit_test
// Self-checking bench for the 6502 execute unit. A scoreboard tracks A, X, Y,
// P and S and predicts every result, including the NMOS decimal ADC and SBC
// behaviour. The bench drives directed corner cases, then random operations
// and BCD sequences. Both channels idle at random, and once the receiver
// holds off long enough to back the unit up.
// ----------------------------------------------------------------------------
module cpu6502_alu_register_unit_test;
    import c65alu_pkg::*;

    localparam logic [5:0] OP_UNUSED_LO = 6'd55;
    localparam logic [5:0] OP_UNUSED_HI = 6'd63;
    localparam int unsigned STALL_LIMIT  = 2000;
    localparam int unsigned HOLD_CYCLES  = 60;
    localparam int unsigned IDLE_PCT     = 35;
    localparam int unsigned MAX_REPORTS  = 10;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] x;
        logic [7:0] y;
        logic [7:0] status;
        logic [7:0] store_data;
        logic       store_valid;
        logic       branch_taken;
    } exec_result_t;

    class exec_scoreboard;
        logic [7:0]   reg_a;
        logic [7:0]   reg_x;
        logic [7:0]   reg_y;
        logic [7:0]   reg_p;
        logic [7:0]   reg_s;
        exec_result_t outcome_q[$];
        int unsigned  mismatches;

        function new();
            reg_a = 8'h00;
            reg_x = 8'h00;
            reg_y = 8'h00;
            reg_p = RST_P;
            reg_s = RST_S;
            mismatches = 0;
        endfunction

        function logic [7:0] nz(logic [7:0] v);
            reg_p[FLAG_Z] = (v == 8'h00);
            reg_p[FLAG_N] = v[7];
            return v;
        endfunction

        function void compare(logic [7:0] r, logic [7:0] m);
            logic [7:0] diff;
            diff = r - m;
            reg_p[FLAG_C] = (r >= m);
            void'(nz(diff));
        endfunction

        function logic [7:0] shift(logic [5:0] op, logic [7:0] v);
            logic       cin;
            logic [7:0] r;
            cin = reg_p[FLAG_C];
            case (op)
                OP_ASL_A, OP_ASL_M: begin
                    reg_p[FLAG_C] = v[7];
                    r = {v[6:0], 1'b0};
                end
                OP_LSR_A, OP_LSR_M: begin
                    reg_p[FLAG_C] = v[0];
                    r = {1'b0, v[7:1]};
                end
                OP_ROL_A, OP_ROL_M: begin
                    reg_p[FLAG_C] = v[7];
                    r = {v[6:0], cin};
                end
                default: begin
                    reg_p[FLAG_C] = v[0];
                    r = {cin, v[7:1]};
                end
            endcase
            return nz(r);
        endfunction

        function void add_with_carry(logic [7:0] m);
            logic [31:0] a, b, c, bin, lo, t;
            a = {24'h0, reg_a};
            b = {24'h0, m};
            c = {31'h0, reg_p[FLAG_C]};
            bin = a + b + c;
            if (!reg_p[FLAG_D]) begin
                reg_p[FLAG_C] = (bin > 32'hFF);
                reg_p[FLAG_V] = ((~(a ^ b) & (a ^ bin) & 32'h80) != 0);
                reg_a = nz(bin[7:0]);
            end else begin
                lo = (a & 32'h0F) + (b & 32'h0F) + c;
                if (lo >= 32'h0A)
                    lo = ((lo + 32'd6) & 32'h0F) + 32'h10;
                t = (a & 32'hF0) + (b & 32'hF0) + lo;
                reg_p[FLAG_Z] = (bin[7:0] == 8'h00);
                reg_p[FLAG_N] = t[7];
                reg_p[FLAG_V] = ((~(a ^ b) & (a ^ t) & 32'h80) != 0);
                if (t >= 32'hA0)
                    t = t + 32'h60;
                reg_p[FLAG_C] = (t >= 32'h100);
                reg_a = t[7:0];
            end
        endfunction

        function void sub_with_borrow(logic [7:0] m);
            logic [31:0] a, b, c, nb, bin, lo, t;
            a = {24'h0, reg_a};
            b = {24'h0, m};
            c = {31'h0, reg_p[FLAG_C]};
            nb = b ^ 32'hFF;
            bin = a + nb + c;
            reg_p[FLAG_C] = (bin > 32'hFF);
            reg_p[FLAG_V] = ((~(a ^ nb) & (a ^ bin) & 32'h80) != 0);
            void'(nz(bin[7:0]));
            if (!reg_p[FLAG_D]) begin
                reg_a = bin[7:0];
            end else begin
                // 32-bit wrap; bit 31 marks a negative digit sum
                lo = (a & 32'h0F) - (b & 32'h0F) + c - 32'd1;
                if (lo[31])
                    lo = ((lo - 32'd6) & 32'h0F) - 32'h10;
                t = (a & 32'hF0) - (b & 32'hF0) + lo;
                if (t[31])
                    t = t - 32'h60;
                reg_a = t[7:0];
            end
        endfunction

        function void note_op(logic [5:0] op, logic [7:0] m);
            exec_result_t r;
            logic [7:0]   sd;
            logic         sv;
            logic         br;
            sd = 8'h00;
            sv = 1'b0;
            br = 1'b0;
            case (op)
                OP_LDA: reg_a = nz(m);
                OP_LDX: reg_x = nz(m);
                OP_LDY: reg_y = nz(m);
                OP_STA: begin sd = reg_a; sv = 1'b1; end
                OP_STX: begin sd = reg_x; sv = 1'b1; end
                OP_STY: begin sd = reg_y; sv = 1'b1; end
                OP_TAX: reg_x = nz(reg_a);
                OP_TAY: reg_y = nz(reg_a);
                OP_TXA: reg_a = nz(reg_x);
                OP_TYA: reg_a = nz(reg_y);
                OP_TSX: reg_x = nz(reg_s);
                OP_TXS: reg_s = reg_x;
                OP_INX: reg_x = nz(reg_x + 8'd1);
                OP_INY: reg_y = nz(reg_y + 8'd1);
                OP_DEX: reg_x = nz(reg_x - 8'd1);
                OP_DEY: reg_y = nz(reg_y - 8'd1);
                OP_INC: begin sd = nz(m + 8'd1); sv = 1'b1; end
                OP_DEC: begin sd = nz(m - 8'd1); sv = 1'b1; end
                OP_ADC: add_with_carry(m);
                OP_SBC: sub_with_borrow(m);
                OP_AND: reg_a = nz(reg_a & m);
                OP_ORA: reg_a = nz(reg_a | m);
                OP_EOR: reg_a = nz(reg_a ^ m);
                OP_CMP: compare(reg_a, m);
                OP_CPX: compare(reg_x, m);
                OP_CPY: compare(reg_y, m);
                OP_BIT: begin
                    reg_p[FLAG_Z] = ((reg_a & m) == 8'h00);
                    reg_p[FLAG_N] = m[7];
                    reg_p[FLAG_V] = m[6];
                end
                OP_ASL_A, OP_LSR_A, OP_ROL_A, OP_ROR_A: reg_a = shift(op, reg_a);
                OP_ASL_M, OP_LSR_M, OP_ROL_M, OP_ROR_M: begin
                    sd = shift(op, m);
                    sv = 1'b1;
                end
                OP_CLC: reg_p[FLAG_C] = 1'b0;
                OP_SEC: reg_p[FLAG_C] = 1'b1;
                OP_CLI: reg_p[FLAG_I] = 1'b0;
                OP_SEI: reg_p[FLAG_I] = 1'b1;
                OP_CLD: reg_p[FLAG_D] = 1'b0;
                OP_SED: reg_p[FLAG_D] = 1'b1;
                OP_CLV: reg_p[FLAG_V] = 1'b0;
                OP_PHA: begin
                    sd = reg_a;
                    sv = 1'b1;
                    reg_s = reg_s - 8'd1;
                end
                OP_PHP: begin
                    sd = reg_p;
                    sd[FLAG_B] = 1'b1;
                    sd[FLAG_U] = 1'b1;
                    sv = 1'b1;
                    reg_s = reg_s - 8'd1;
                end
                OP_PLA: begin
                    reg_s = reg_s + 8'd1;
                    reg_a = nz(m);
                end
                OP_PLP: begin
                    reg_s = reg_s + 8'd1;
                    reg_p = m;
                    reg_p[FLAG_B] = 1'b0;
                    reg_p[FLAG_U] = 1'b1;
                end
                OP_BPL: br = !reg_p[FLAG_N];
                OP_BMI: br = reg_p[FLAG_N];
                OP_BVC: br = !reg_p[FLAG_V];
                OP_BVS: br = reg_p[FLAG_V];
                OP_BCC: br = !reg_p[FLAG_C];
                OP_BCS: br = reg_p[FLAG_C];
                OP_BNE: br = !reg_p[FLAG_Z];
                OP_BEQ: br = reg_p[FLAG_Z];
                default: ;
            endcase
            r.acc          = reg_a;
            r.x            = reg_x;
            r.y            = reg_y;
            r.status       = reg_p;
            r.store_data   = sv ? sd : 8'h00;
            r.store_valid  = sv;
            r.branch_taken = br;
            outcome_q.push_back(r);
        endfunction

        function void check_result(exec_result_t got);
            exec_result_t exp;
            if (outcome_q.size() == 0) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS)
                    $display("unexpected result transfer: a=%h x=%h y=%h p=%h",
                             got.acc, got.x, got.y, got.status);
                return;
            end
            exp = outcome_q.pop_front();
            if (got.acc !== exp.acc || got.x !== exp.x || got.y !== exp.y ||
                got.status !== exp.status || got.store_data !== exp.store_data ||
                got.store_valid !== exp.store_valid ||
                got.branch_taken !== exp.branch_taken) begin
                mismatches++;
                if (mismatches <= MAX_REPORTS) begin
                    $display("mismatch exp: a=%h x=%h y=%h p=%h sd=%h sv=%b br=%b",
                             exp.acc, exp.x, exp.y, exp.status, exp.store_data,
                             exp.store_valid, exp.branch_taken);
                    $display("         got: a=%h x=%h y=%h p=%h sd=%h sv=%b br=%b",
                             got.acc, got.x, got.y, got.status, got.store_data,
                             got.store_valid, got.branch_taken);
                end
            end
        endfunction

        function int unsigned pending();
            return outcome_q.size();
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;

    c65alu_in_if  in_ch();
    c65alu_out_if out_ch();

    cpu6502_alu_register_unit dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    exec_scoreboard sb;
    bit             idling_on;
    bit             hold_req;
    int unsigned    stall_cycles;

    initial begin
        i_clk = 1'b0;
        i_rst_n = 1'b0;
        in_ch.valid = 1'b0;
        in_ch.op = OP_NOP;
        in_ch.operand = 8'h00;
        out_ch.ready = 1'b0;
        idling_on = 1'b1;
        hold_req = 1'b0;
        stall_cycles = 0;
        sb = new();
    end

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_ch.valid && in_ch.ready)
                sb.note_op(in_ch.op, in_ch.operand);
            if (out_ch.valid && out_ch.ready)
                sb.check_result(exec_result_t'{out_ch.acc_out, out_ch.x_out,
                                               out_ch.y_out, out_ch.status_out,
                                               out_ch.store_data, out_ch.store_valid,
                                               out_ch.branch_taken});
        end
    end

    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("status: fail");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    // receiver; a requested hold-off is counted here
    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_req) begin
                out_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge i_clk);
                hold_req = 1'b0;
            end else begin
                out_ch.ready = idling_on ? ($urandom_range(99) >= IDLE_PCT) : 1'b1;
            end
        end
    end

    task automatic send_op(input logic [5:0] op, input logic [7:0] operand);
        @(negedge i_clk);
        while (idling_on && $urandom_range(99) < IDLE_PCT) begin
            in_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid = 1'b1;
        in_ch.op = op;
        in_ch.operand = operand;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
    endtask

    // mostly any code with any byte, with short decimal-mode sequences mixed in
    task automatic send_random(input int unsigned n_items);
        int unsigned sent;
        logic [7:0]  bcd;
        sent = 0;
        while (sent < n_items) begin
            if ($urandom_range(7) == 0) begin
                send_op(OP_SED, 8'($urandom_range(255)));
                bcd = 8'(($urandom_range(9) << 4) | $urandom_range(9));
                send_op(OP_LDA, bcd);
                repeat (2) begin
                    bcd = 8'(($urandom_range(9) << 4) | $urandom_range(9));
                    send_op($urandom_range(1) ? OP_ADC : OP_SBC, bcd);
                end
                sent += 4;
            end else begin
                send_op(6'($urandom_range(63)), 8'($urandom_range(255)));
                sent++;
            end
        end
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // stack wrap, pushed and pulled status, decimal digits above nine,
        // unused codes
        send_op(OP_LDA, 8'hFF);
        send_op(OP_LDX, 8'h00);
        send_op(OP_TXS, 8'h5A);
        send_op(OP_PHA, 8'h00);
        send_op(OP_PLA, 8'h00);
        send_op(OP_PHP, 8'hFF);
        send_op(OP_PLP, 8'hFF);
        send_op(OP_BMI, 8'h00);
        send_op(OP_BVS, 8'h00);
        send_op(OP_PLP, 8'h00);
        send_op(OP_BEQ, 8'h00);
        send_op(OP_BPL, 8'h00);
        send_op(OP_SED, 8'h00);
        send_op(OP_LDA, 8'h9F);
        send_op(OP_ADC, 8'hFF);
        send_op(OP_SEC, 8'h00);
        send_op(OP_SBC, 8'h0A);
        send_op(OP_SBC, 8'hFF);
        send_op(OP_CLD, 8'h00);
        send_op(OP_ADC, 8'h80);
        send_op(OP_UNUSED_HI, 8'hFF);
        send_op(OP_UNUSED_LO, 8'h00);
        send_op(OP_BIT, 8'hC0);
        send_op(OP_ROR_M, 8'hFF);
        send_op(OP_CMP, 8'hFF);

        idling_on = 1'b0;
        send_random(150);

        @(posedge i_clk);
        hold_req = 1'b1;
        send_random(30);

        idling_on = 1'b1;
        send_random(270);

        @(negedge i_clk);
        in_ch.valid = 1'b0;

        while (sb.pending() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
